@@ rtl/core/latg_pkg.sv @@
// Shared constants, operation codes and controller/datapath interface types.
package latg_pkg;

    // Grid geometry
    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 128;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);

    // Size registers
    localparam int SIZE_W = 8;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(100);
    localparam logic [SIZE_W-1:0] COLS_MAX   = SIZE_W'(MAX_COLS);
    localparam logic [SIZE_W-1:0] ROWS_MAX   = SIZE_W'(MAX_ROWS);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(1);

    // Generation sweep counter: must hold MAX_ROWS + 3
    localparam int STEP_CNT_W = $clog2(MAX_ROWS + 4);

    typedef enum logic [1:0] {
        OP_TOGGLE = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_STEP   = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load;        // latch request coordinates
        logic             rd_coord;    // read the addressed row instead of rd_row
        logic [ROW_W-1:0] rd_row;      // sweep read address
        logic             shift;       // advance the three-row window
        logic             use_first;   // shift in the saved original row 0
        logic             save_first;  // capture original row 0
        logic             step_wr;     // write back one new generation row
        logic [ROW_W-1:0] wr_row;      // sweep write address
        logic             mod_en;      // toggle/read cycle on the addressed row
        logic             mod_toggle;  // flip the addressed cell
        logic             clear;       // kill every cell
        logic             res_clr;     // result is zero
        logic             out_load;    // move result into the output register
    } latg_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [SIZE_W-1:0] eff_rows;
    } latg_sts_t;

    // Saturate a size register into [3, max]
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_MIN)
            r = SIZE_MIN;
        else if (v > max)
            r = max;
        else
            r = v;
        return r;
    endfunction

endpackage

@@ rtl/core/latg_ctrl.sv @@
// Controller state machine: request sequencing, generation sweep and result hand-off.
module latg_ctrl
    import latg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    output logic       out_valid,
    input  logic       out_stall,
    input  latg_sts_t  sts,
    output latg_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MOD,
        S_STEP,
        S_DONE
    } state_t;

    // step counter value of the first row write, after the window fill
    localparam logic [STEP_CNT_W-1:0] STEP_LEAD = STEP_CNT_W'(4);
    localparam logic [STEP_CNT_W-1:0] SAVE_AT   = STEP_CNT_W'(2);

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [STEP_CNT_W-1:0]   k_reg, k_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    accept;
    logic [STEP_CNT_W-1:0]   k_last;
    logic [STEP_CNT_W-1:0]   k_first_in;

    assign accept     = in_valid && (state_reg == S_IDLE);
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign k_last     = STEP_CNT_W'(sts.eff_rows + SIZE_W'(3));
    assign k_first_in = STEP_CNT_W'(sts.eff_rows + SIZE_W'(2));

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // output register drains independently of the state
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    op_next  = op_t'(operation);
                    unique case (op_t'(operation))
                        OP_CLEAR:
                        begin
                            cmd.clear   = 1'b1;
                            cmd.res_clr = 1'b1;
                            state_next  = S_DONE;
                        end
                        OP_STEP:
                        begin
                            k_next     = '0;
                            state_next = S_STEP;
                        end
                        OP_TOGGLE, OP_READ:
                        begin
                            state_next = S_RD;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                cmd.rd_coord = 1'b1;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_en     = 1'b1;
                cmd.mod_toggle = (op_reg == OP_TOGGLE);
                state_next     = S_DONE;
            end
            S_STEP:
            begin
                // read row k-1 (row n-1 first); the window shifts it in on the next cycle
                if (k_reg == '0)
                    cmd.rd_row = ROW_W'(sts.eff_rows - SIZE_W'(1));
                else
                    cmd.rd_row = ROW_W'(k_reg - STEP_CNT_W'(1));
                cmd.shift      = (k_reg != '0);
                cmd.save_first = (k_reg == SAVE_AT);
                cmd.use_first  = (k_reg == k_first_in);
                cmd.step_wr    = (k_reg >= STEP_LEAD);
                cmd.wr_row     = ROW_W'(k_reg - STEP_LEAD);
                if (k_reg == k_last)
                begin
                    cmd.res_clr = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    k_next = k_reg + STEP_CNT_W'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_READ;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("request accepted but input not stalled next cycle");

    a_step_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_wr |-> (SIZE_W'(cmd.wr_row) < sts.eff_rows))
        else $error("generation write beyond rows in use");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside hand-off state");

    a_sweep_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STEP) |-> (k_reg <= k_last))
        else $error("generation sweep counter overran");
`endif

endmodule

@@ rtl/core/latg_dp.sv @@
// Datapath: size registers, grid memory with row valid bits, row window and B3/S23 row update.
module latg_dp
    import latg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic [COL_W-1:0]     col,
    input  logic [ROW_W-1:0]     row,
    input  latg_cmd_t            cmd,
    output latg_sts_t            sts,
    output logic                 cell_alive
);

    logic [SIZE_W-1:0]   cols_reg;
    logic [SIZE_W-1:0]   rows_reg;
    logic [SIZE_W-1:0]   eff_cols;
    logic [SIZE_W-1:0]   eff_rows;
    logic [COL_W-1:0]    last_col;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;

    logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] vld_reg;
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                rd_vld_reg;
    logic [ROW_W-1:0]    rd_addr;
    logic [MAX_COLS-1:0] rdata;

    logic [MAX_COLS-1:0] prev_reg, cur_reg, nxt_reg, first_reg;
    logic [MAX_COLS-1:0] shift_in;
    logic [MAX_COLS-1:0] in_use_mask;
    logic [MAX_COLS-1:0] last_mask;
    logic [MAX_COLS-1:0] new_row;

    logic                in_area;
    logic                hit_bit;
    logic [MAX_COLS-1:0] flip_mask;
    logic                res_reg;
    logic                cell_alive_reg;

    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic [MAX_COLS-1:0] wr_data;

    // Effective sizes
    assign eff_cols     = clamp_size(cols_reg, COLS_MAX);
    assign eff_rows     = clamp_size(rows_reg, ROWS_MAX);
    assign last_col     = COL_W'(eff_cols - SIZE_W'(1));
    assign sts.eff_rows = eff_rows;

    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
            in_use_mask[c] = (SIZE_W'(c) < eff_cols);
    end

    assign last_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << last_col;

    // Read port; rows never written since reset or clear read as dead
    assign rd_addr = cmd.rd_coord ? row_reg : cmd.rd_row;
    assign rdata   = rd_vld_reg ? rd_data_reg : '0;

    // Window shift source: original row 0 when the sweep wraps
    assign shift_in = cmd.use_first ? first_reg : rdata;

    // One new generation row from the three-row window
    always_comb
    begin
        logic [MAX_COLS-1:0] p_l, p_r, c_l, c_r, n_l, n_r;
        logic [3:0]          cnt;
        logic                rule;
        p_l = {prev_reg[MAX_COLS-2:0], prev_reg[last_col]};
        c_l = {cur_reg[MAX_COLS-2:0],  cur_reg[last_col]};
        n_l = {nxt_reg[MAX_COLS-2:0],  nxt_reg[last_col]};
        p_r = ({prev_reg[0], prev_reg[MAX_COLS-1:1]} & ~last_mask)
            | (last_mask & {MAX_COLS{prev_reg[0]}});
        c_r = ({cur_reg[0],  cur_reg[MAX_COLS-1:1]}  & ~last_mask)
            | (last_mask & {MAX_COLS{cur_reg[0]}});
        n_r = ({nxt_reg[0],  nxt_reg[MAX_COLS-1:1]}  & ~last_mask)
            | (last_mask & {MAX_COLS{nxt_reg[0]}});
        for (int c = 0; c < MAX_COLS; c++)
        begin
            cnt = 4'(p_l[c]) + 4'(prev_reg[c]) + 4'(p_r[c])
                + 4'(c_l[c]) + 4'(c_r[c])
                + 4'(n_l[c]) + 4'(nxt_reg[c]) + 4'(n_r[c]);
            rule = (cnt == 4'd3) || ((cnt == 4'd2) && cur_reg[c]);
            // cells outside the columns in use keep their state
            new_row[c] = in_use_mask[c] ? rule : cur_reg[c];
        end
    end

    // Toggle / read on the addressed cell
    assign in_area   = (SIZE_W'(col_reg) < eff_cols) && (SIZE_W'(row_reg) < eff_rows);
    assign hit_bit   = rdata[col_reg];
    assign flip_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << col_reg;

    // Write port
    assign wr_en   = cmd.step_wr || (cmd.mod_en && cmd.mod_toggle && in_area);
    assign wr_addr = cmd.step_wr ? cmd.wr_row : row_reg;
    assign wr_data = cmd.step_wr ? new_row : (rdata ^ flip_mask);

    assign cell_alive = cell_alive_reg;

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= SIZE_RESET;
            rows_reg <= SIZE_RESET;
        end
        else if (cfg_write_en)
        begin
            if (cfg_index == REG_COLS)
                cols_reg <= cfg_data;
            else if (cfg_index == REG_ROWS)
                rows_reg <= cfg_data;
        end
    end

    // Row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (cmd.clear)
            vld_reg <= '0;
        else if (wr_en)
            vld_reg[wr_addr] <= 1'b1;
    end

    // Grid memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[wr_addr] <= wr_data;
        rd_data_reg <= grid_mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    // Request coordinates, window and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            col_reg <= col;
            row_reg <= row;
        end
        if (cmd.shift)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= nxt_reg;
            nxt_reg  <= shift_in;
        end
        if (cmd.save_first)
            first_reg <= rdata;
        if (cmd.res_clr)
            res_reg <= 1'b0;
        else if (cmd.mod_en)
            res_reg <= in_area && (hit_bit ^ cmd.mod_toggle);
        if (cmd.out_load)
            cell_alive_reg <= res_reg;
    end

endmodule

@@ rtl/core/life_automaton_toroidal_grid.sv @@
// Top level: B3/S23 life grid on a torus with configurable size.
//
// Requests arrive on in_valid/in_stall with operation, col and row; one result
// (cell_alive) leaves per request on out_valid/out_stall. A request is taken
// when valid is high and stall is low. One request is processed at a time;
// in_stall is high from acceptance until the result has moved to the output
// register, which may still be waiting on the receiver while the next request
// is taken.
// A clear goes straight to the hand-off state; a toggle or read first passes
// through a memory read state and a modify state; a generation step sweeps
// every row in use before the hand-off. With no stall the next request can be
// taken in the same cycle that out_valid rises. The step sweeps the grid
// memory (one read and one write port) one row per cycle after the window
// fill; a toggle costs one memory read and one write, a read only the memory
// read. Size registers are written through cfg_write_en/cfg_index/cfg_data;
// the user must write them only while idle, which the block does not enforce.
// Reset makes every cell dead (per-row valid bits, no clearing pass) and sets
// both sizes to 100. If out_stall holds a result, a finished request waits
// in its hand-off state and input stays stalled.
module life_automaton_toroidal_grid
    import latg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           operation,
    input  logic [COL_W-1:0]     col,
    input  logic [ROW_W-1:0]     row,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 cell_alive
);

    latg_cmd_t cmd;
    latg_sts_t sts;

    latg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    latg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .col          (col),
        .row          (row),
        .cmd          (cmd),
        .sts          (sts),
        .cell_alive   (cell_alive)
    );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the toroidal B3/S23 life grid.
module testbench
    import latg_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 10;
    localparam int REPORT_MAX      = 10;

    // One expected result with the request that caused it
    typedef struct {
        op_t         op;
        int unsigned c;
        int unsigned r;
        bit          alive;
    } cell_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_COLS;
    logic [SIZE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           operation = OP_READ;
    logic [COL_W-1:0]     col = '0;
    logic [ROW_W-1:0]     row = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 cell_alive;

    // Predictor state: one bit per cell, bit index is the column
    logic [MAX_COLS-1:0] board [MAX_ROWS];
    logic [SIZE_W-1:0]   cols_reg = SIZE_RESET;
    logic [SIZE_W-1:0]   rows_reg = SIZE_RESET;

    cell_result_t expected_cells [$];
    cell_result_t oldest;
    int           failures = 0;
    int           cycle_count = 0;
    bit           idling_on = 1'b1;
    int           sender_calm = 0;
    int           hold_off_asked = 0;
    int           hold_off_served = 0;

    life_automaton_toroidal_grid i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .col          (col),
        .row          (row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cell_alive   (cell_alive)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Size register value saturated into the legal range
    function automatic int unsigned live_extent(input logic [SIZE_W-1:0] v,
                                                input int unsigned top);
        int unsigned e;
        if (v < 3)
            e = 3;
        else if (v > top)
            e = top;
        else
            e = v;
        return e;
    endfunction

    // One generation over the area in use; cells outside it are left alone
    function automatic void advance_generation();
        logic [MAX_COLS-1:0] nxt [MAX_ROWS];
        int unsigned nc, nr, n;
        int rr, cc;
        nc = live_extent(cols_reg, MAX_COLS);
        nr = live_extent(rows_reg, MAX_ROWS);
        nxt = board;
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if (dr != 0 || dc != 0)
                        begin
                            rr = (r + dr + nr) % nr;
                            cc = (c + dc + nc) % nc;
                            n += board[rr][cc];
                        end
                    end
                end
                nxt[r][c] = (n == 3) ? 1'b1 : (n == 2) ? board[r][c] : 1'b0;
            end
        end
        board = nxt;
    endfunction

    // Apply one request to the predicted grid and return the expected cell state
    function automatic bit grid_apply(input op_t op, input int unsigned c, input int unsigned r);
        bit hit;
        bit alive;
        hit = (c < live_extent(cols_reg, MAX_COLS)) && (r < live_extent(rows_reg, MAX_ROWS));
        alive = 1'b0;
        case (op)
            OP_TOGGLE:
            begin
                if (hit)
                begin
                    board[r][c] = ~board[r][c];
                    alive = board[r][c];
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < MAX_ROWS; i++)
                    board[i] = '0;
            end
            OP_STEP:
                advance_generation();
            default:
            begin
                if (hit)
                    alive = board[r][c];
            end
        endcase
        return alive;
    endfunction

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Offer one request, wait for it to be taken, then queue its expected result
    task automatic send_request(input op_t op, input int unsigned c, input int unsigned r);
        int gap;
        cell_result_t item;
        gap = 0;
        if (sender_calm > 0)
            sender_calm--;
        else if ($urandom_range(0, 29) == 0)
            sender_calm = 20;
        if (idling_on && sender_calm == 0 && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        col       <= COL_W'(c);
        row       <= ROW_W'(r);
        do
            @(posedge clk);
        while (in_stall);
        item.op    = op;
        item.c     = c;
        item.r     = r;
        item.alive = grid_apply(op, c, r);
        expected_cells.push_back(item);
    endtask

    // Random request: mostly toggles and reads inside the area in use
    task automatic random_request(input int step_pct);
        int pick;
        op_t op;
        int unsigned c, r;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            op = OP_CLEAR;
        else if (pick < 2 + step_pct)
            op = OP_STEP;
        else if (pick < 51 + step_pct / 2)
            op = OP_TOGGLE;
        else
            op = OP_READ;
        if ($urandom_range(0, 99) < 85)
        begin
            c = $urandom_range(0, live_extent(cols_reg, MAX_COLS) - 1);
            r = $urandom_range(0, live_extent(rows_reg, MAX_ROWS) - 1);
        end
        else
        begin
            c = $urandom_range(0, MAX_COLS - 1);
            r = $urandom_range(0, MAX_ROWS - 1);
        end
        send_request(op, c, r);
    endtask

    // Stop offering and wait until every result has come back
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both size registers; only called while the block is idle
    task automatic set_grid_size(input logic [SIZE_W-1:0] cols_v,
                                 input logic [SIZE_W-1:0] rows_v);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= REG_COLS;
        cfg_data     <= cols_v;
        @(negedge clk);
        cfg_index    <= REG_ROWS;
        cfg_data     <= rows_v;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        cols_reg = cols_v;
        rows_reg = rows_v;
    endtask

    // Field extremes, every operation, wrap at both edges, default size
    task automatic test_basic_operations();
        send_request(OP_TOGGLE, 0, 0);
        send_request(OP_READ, 0, 0);
        send_request(OP_TOGGLE, 99, 99);
        send_request(OP_READ, 99, 99);
        send_request(OP_TOGGLE, 127, 127);
        send_request(OP_READ, 127, 127);
        send_request(OP_TOGGLE, 100, 5);
        send_request(OP_READ, 5, 100);
        send_request(OP_TOGGLE, 0, 0);
        // blinker straddling the column edge on row 0
        send_request(OP_TOGGLE, 99, 0);
        send_request(OP_TOGGLE, 0, 0);
        send_request(OP_TOGGLE, 1, 0);
        send_request(OP_STEP, 0, 0);
        send_request(OP_READ, 0, 99);
        send_request(OP_READ, 0, 1);
        send_request(OP_READ, 99, 0);
        send_request(OP_STEP, 127, 127);
        send_request(OP_READ, 0, 0);
        send_request(OP_CLEAR, 0, 0);
        send_request(OP_READ, 0, 0);
        send_request(OP_READ, 99, 99);
        send_request(OP_STEP, 0, 0);
        send_request(OP_READ, 1, 0);
        quiesce();
    endtask

    // Size registers outside the legal range saturate
    task automatic test_size_saturation();
        set_grid_size(8'd0, 8'd255);
        send_request(OP_TOGGLE, 2, 127);
        send_request(OP_READ, 2, 127);
        send_request(OP_TOGGLE, 3, 0);
        send_request(OP_TOGGLE, 1, 126);
        send_request(OP_TOGGLE, 0, 0);
        send_request(OP_STEP, 0, 0);
        send_request(OP_READ, 2, 127);
        send_request(OP_READ, 1, 0);
        quiesce();
        set_grid_size(8'd255, 8'd1);
        send_request(OP_TOGGLE, 127, 2);
        send_request(OP_READ, 127, 2);
        send_request(OP_TOGGLE, 0, 3);
        send_request(OP_TOGGLE, 126, 1);
        send_request(OP_TOGGLE, 0, 0);
        send_request(OP_STEP, 0, 0);
        send_request(OP_READ, 127, 0);
        send_request(OP_READ, 126, 1);
        quiesce();
        set_grid_size(8'd129, 8'd2);
        send_request(OP_READ, 127, 2);
        send_request(OP_STEP, 0, 0);
        send_request(OP_READ, 0, 2);
        quiesce();
    endtask

    // Cells beyond a shrunken area survive steps and reappear on enlarging
    task automatic test_outside_area_kept();
        set_grid_size(8'd128, 8'd128);
        send_request(OP_CLEAR, 0, 0);
        send_request(OP_TOGGLE, 60, 60);
        send_request(OP_TOGGLE, 61, 60);
        send_request(OP_TOGGLE, 62, 60);
        send_request(OP_TOGGLE, 1, 1);
        quiesce();
        set_grid_size(8'd20, 8'd20);
        send_request(OP_STEP, 0, 0);
        send_request(OP_STEP, 0, 0);
        send_request(OP_READ, 1, 1);
        send_request(OP_READ, 61, 60);
        quiesce();
        set_grid_size(8'd128, 8'd128);
        send_request(OP_READ, 61, 60);
        send_request(OP_READ, 60, 60);
        send_request(OP_STEP, 0, 0);
        send_request(OP_READ, 61, 59);
        quiesce();
    endtask

    // Random phases over a range of grid sizes, extremes among them
    task automatic test_random_generations();
        logic [SIZE_W-1:0] phase_cols [9] = '{8'd3, 8'd128, 8'd5, 8'd10, 8'd0,
                                              8'd255, 8'd16, 8'd8, 8'd129};
        logic [SIZE_W-1:0] phase_rows [9] = '{8'd3, 8'd128, 8'd7, 8'd4, 8'd255,
                                              8'd3, 8'd16, 8'd12, 8'd200};
        int phase_items [9] = '{120, 60, 150, 150, 80, 80, 150, 150, 40};
        int phase_steps [9] = '{15, 3, 15, 15, 10, 10, 15, 15, 3};
        for (int p = 0; p < 9; p++)
        begin
            set_grid_size(phase_cols[p], phase_rows[p]);
            for (int i = 0; i < phase_items[p]; i++)
                random_request(phase_steps[p]);
            quiesce();
        end
    endtask

    // Receiver holds off for a long stretch while requests keep coming
    task automatic test_input_backpressure();
        set_grid_size(8'd6, 8'd5);
        hold_off_asked++;
        for (int i = 0; i < 25; i++)
            random_request(15);
        quiesce();
    endtask

    // Closing stretch with no idling on either side
    task automatic test_steady_stream();
        idling_on = 1'b0;
        set_grid_size(8'd6, 8'd6);
        for (int i = 0; i < 100; i++)
            random_request(15);
        quiesce();
    endtask

    // Receiver: random stall bursts, calm stretches and the long hold-off
    initial
    begin : receiver
        int burst_left;
        int calm_left;
        int hold_left;
        burst_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_off_served != hold_off_asked)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_off_served++;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else if (idling_on && calm_left == 0 && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                burst_left = $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 99) == 0)
                calm_left = 60;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cells.size() == 0)
                report_failure($sformatf("result %0b with no request outstanding", cell_alive));
            else
            begin
                oldest = expected_cells.pop_front();
                if (cell_alive !== oldest.alive)
                    report_failure($sformatf("%s col %0d row %0d: expected %0b got %0b",
                                             oldest.op.name(), oldest.c, oldest.r,
                                             oldest.alive, cell_alive));
            end
        end
    end

    initial
    begin
        for (int i = 0; i < MAX_ROWS; i++)
            board[i] = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_basic_operations();
        test_size_saturation();
        test_outside_area_kept();
        test_random_generations();
        test_input_backpressure();
        test_steady_stream();
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
